// ----- hw/rtl/xfd_pkg.sv -----
// Shared types and constants of the XOR frame deframer.
// Used by xor_frame_deframer_unit and its checker; no dependencies.
package xfd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ENCRYPT_ENABLE = 2'd0;
  localparam logic [1:0] CFG_KEY_LENGTH     = 2'd1;
  localparam logic [1:0] CFG_KEY_BYTES      = 2'd2;

  // Header byte positions.
  localparam logic [2:0] HDR_OPCODE = 3'd0;
  localparam logic [2:0] HDR_LEN_HI = 3'd2;
  localparam logic [2:0] HDR_LEN_LO = 3'd3;
  localparam logic [2:0] HDR_SEQ_0  = 3'd4;
  localparam logic [2:0] HDR_LAST   = 3'd7;

  // Result kinds.
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  opcode;
    logic [15:0] payload_length;
    logic [31:0] sequence_res;
    logic [7:0]  data_byte;
    logic        last;
  } res_t;

endpackage

// ----- hw/rtl/xor_frame_deframer_unit.sv -----
// A result goes to the output register, or to the skid entry while the
// output is stalled. Throughput: one byte per cycle while in_stall is low;
// the descramble, header parse and length compare all sit between the input
// transfer and the output register. A two-entry output buffer (register plus
// skid) keeps input running while a result waits. Synchronous active-low
// reset clears config, state, buffer. Depends on xfd_pkg.
module xor_frame_deframer_unit #(
  parameter int MAX_KEY_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  // Input byte channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_kind,
  output logic [7:0]  out_opcode,
  output logic [15:0] out_payload_length,
  output logic [31:0] out_sequence_res,
  output logic [7:0]  out_data_byte,
  output logic        out_last
);
  import xfd_pkg::*;

  localparam int KIW = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [3:0] MAX_KLEN = 4'(MAX_KEY_BYTES);

  // Configuration registers.
  logic        enc_en_r;
  logic [3:0]  key_len_r;
  logic [63:0] key_bytes_r;

  // Frame state.
  logic           in_payload_r, in_payload_nxt;
  logic [15:0]    byte_pos_r, byte_pos_nxt;
  logic [KIW-1:0] key_idx_r, key_idx_nxt;
  logic [7:0]     held_opc_r, held_opc_nxt;
  logic [15:0]    held_len_r, held_len_nxt;
  logic [31:0]    held_seq_r, held_seq_nxt;

  // Output register and skid entry.
  logic out_valid_r, skid_valid_r;
  res_t out_r, skid_r;

  logic       in_xfer, out_xfer;
  logic [3:0] klen;
  logic [3:0] k_use, k_inc;
  logic [7:0] key_byte, b;
  logic [2:0] hpos;
  logic       res_valid;
  res_t       res;

  assign in_stall = skid_valid_r;
  assign in_xfer  = in_valid && !skid_valid_r;
  assign out_xfer = out_valid_r && !out_stall;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_en_r    <= 1'b0;
      key_len_r   <= 4'd0;
      key_bytes_r <= 64'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ENCRYPT_ENABLE: enc_en_r    <= cfg_wdata[0];
        CFG_KEY_LENGTH:     key_len_r   <= cfg_wdata[3:0];
        CFG_KEY_BYTES:      key_bytes_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Key selection: saturate the length and wrap the key index.
  always_comb begin
    klen     = (key_len_r > MAX_KLEN) ? MAX_KLEN : key_len_r;
    k_use    = (4'(key_idx_r) >= klen) ? 4'd0 : 4'(key_idx_r);
    k_inc    = k_use + 4'd1;
    key_byte = 8'(key_bytes_r >> {k_use[KIW-1:0], 3'b000});
    if (klen != 4'd0 && enc_en_r) begin
      b = in_rx_byte ^ key_byte;
    end else begin
      b = in_rx_byte;
    end
  end

  // Header parse and payload counting for the byte in transfer.
  always_comb begin
    in_payload_nxt = in_payload_r;
    byte_pos_nxt   = byte_pos_r;
    held_opc_nxt   = held_opc_r;
    held_len_nxt   = held_len_r;
    held_seq_nxt   = held_seq_r;
    res_valid      = 1'b0;
    hpos           = byte_pos_r[2:0];
    if (klen == 4'd0 || k_inc >= klen) begin
      key_idx_nxt = '0;
    end else begin
      key_idx_nxt = k_inc[KIW-1:0];
    end

    if (!in_payload_r) begin
      if (hpos == HDR_OPCODE) begin
        held_opc_nxt = b;
      end else if (hpos == HDR_LEN_HI || hpos == HDR_LEN_LO) begin
        held_len_nxt = {held_len_r[7:0], b};
      end else if (hpos >= HDR_SEQ_0) begin
        held_seq_nxt = {held_seq_r[23:0], b};
      end
      if (hpos != HDR_LAST) begin
        byte_pos_nxt = {13'd0, hpos + 3'd1};
      end else begin
        res_valid    = 1'b1;
        byte_pos_nxt = 16'd0;
        if (held_len_r == 16'd0) begin
          // Empty payload: the next byte opens a new frame.
          key_idx_nxt = '0;
        end else begin
          in_payload_nxt = 1'b1;
        end
      end
    end else begin
      res_valid = 1'b1;
      if (({1'b0, byte_pos_r} + 17'd1) >= {1'b0, held_len_r}) begin
        in_payload_nxt = 1'b0;
        byte_pos_nxt   = 16'd0;
        key_idx_nxt    = '0;
      end else begin
        byte_pos_nxt = byte_pos_r + 16'd1;
      end
    end

    res.kind           = in_payload_r ? KIND_DATA : KIND_HEADER;
    res.opcode         = held_opc_nxt;
    res.payload_length = held_len_nxt;
    res.sequence_res   = held_seq_nxt;
    res.data_byte      = in_payload_r ? b : 8'd0;
    res.last           = in_payload_r ? (({1'b0, byte_pos_r} + 17'd1) >= {1'b0, held_len_r})
                                      : (held_len_r == 16'd0);
  end

  // Frame state registers advance on each input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_payload_r <= 1'b0;
      byte_pos_r   <= 16'd0;
      key_idx_r    <= '0;
      held_opc_r   <= 8'd0;
      held_len_r   <= 16'd0;
      held_seq_r   <= 32'd0;
    end else if (in_xfer) begin
      in_payload_r <= in_payload_nxt;
      byte_pos_r   <= byte_pos_nxt;
      key_idx_r    <= key_idx_nxt;
      held_opc_r   <= held_opc_nxt;
      held_len_r   <= held_len_nxt;
      held_seq_r   <= held_seq_nxt;
    end
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_xfer) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_xfer && res_valid) begin
      if (!out_valid_r || out_xfer) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  // Payload of the buffer entries; no reset needed.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_xfer) begin
        out_r <= skid_r;
      end
    end else if (in_xfer && res_valid) begin
      if (!out_valid_r || out_xfer) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = out_r.kind;
  assign out_opcode         = out_r.opcode;
  assign out_payload_length = out_r.payload_length;
  assign out_sequence_res   = out_r.sequence_res;
  assign out_data_byte      = out_r.data_byte;
  assign out_last           = out_r.last;

endmodule

// ----- hw/rtl/xfd_checker.sv -----
// Port-level checker for xor_frame_deframer_unit, bound into each of its instances.
// Depends on xfd_pkg.
module xfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_kind,
  input logic [15:0] out_payload_length,
  input logic [7:0]  out_data_byte,
  input logic        out_last
);
  import xfd_pkg::*;

  // After reset no result is pending and input is open.
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_stall)
    else $error("result or stall left over after reset");

  // The input only stalls when the output register already holds a result.
  a_stall_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  // A header result is last exactly when its frame has no payload, and its data byte is zero.
  a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_HEADER |->
      out_last == (out_payload_length == 16'd0) && out_data_byte == 8'd0)
    else $error("header result last flag disagrees with its length");

  // A stalled result holds its kind, last flag and data byte.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_last)
      && $stable(out_data_byte))
    else $error("stalled result changed");

endmodule

bind xor_frame_deframer_unit xfd_checker u_xfd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_kind           (out_kind),
  .out_payload_length (out_payload_length),
  .out_data_byte      (out_data_byte),
  .out_last           (out_last)
);
